// ===== rtl/core/can_id_filter_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// can_id_filter_table_top_macros
// Assertion macros used by the filter table top.
// ----------------------------------------------------------------------------
`ifndef CAN_ID_FILTER_TABLE_TOP_MACROS_SVH
`define CAN_ID_FILTER_TABLE_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CIFT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CIFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cift_pkg.sv =====
// ----------------------------------------------------------------------------
// cift_pkg
// Types and constants of the CAN identifier filter table.
// ----------------------------------------------------------------------------
package cift_pkg;

  localparam int unsigned EntriesDef = 32;

  localparam int unsigned IdW     = 29;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CntW    = 32;
  localparam int unsigned NumKeys = 3;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 72;

  // Key positions within one lookup
  localparam int unsigned KeyExact = 0;
  localparam int unsigned KeyPrio  = 1;
  localparam int unsigned KeyBcast = 2;

  localparam logic [IdW-1:0] PrioMask  = 29'h3FF_FFFF;
  localparam logic [IdW-1:0] PgnMask   = 29'h3FF_FF00;
  localparam logic [IdW-1:0] BcastAddr = 29'h000_00FE;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_EXACT = 2'd0,
    KIND_PRIO  = 2'd1,
    KIND_BCAST = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic               done;
    logic [NumKeys-1:0] hit;
    logic               free_found;
  } scan_status_t;

endpackage

// ===== rtl/core/cift_ram.sv =====
// ----------------------------------------------------------------------------
// cift_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cift_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cift_scan.sv =====
// ----------------------------------------------------------------------------
// cift_scan
// Sweeps the key memory one entry per cycle and records, for each of the
// three search keys, the lowest valid entry holding it, plus the lowest
// free entry.
// ----------------------------------------------------------------------------
module cift_scan #(
  parameter int unsigned Entries = cift_pkg::EntriesDef,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cift_pkg::IdW-1:0]  key_i [cift_pkg::NumKeys],
  input  logic [Entries-1:0]        valid_i,
  output logic                      rd_en_o,
  output logic [IdxW-1:0]           rd_addr_o,
  input  logic [cift_pkg::IdW-1:0]  rd_data_i,
  output cift_pkg::scan_status_t    status_o,
  output logic [IdxW-1:0]           hit_idx_o [cift_pkg::NumKeys],
  output logic [IdxW-1:0]           free_idx_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  logic                         busy_q, busy_d;
  logic [IdxW-1:0]              addr_q, addr_d;
  logic                         cmp_vld_q;
  logic [IdxW-1:0]              cmp_idx_q;
  logic                         done_q;
  logic [cift_pkg::NumKeys-1:0] hit_q, hit_d;
  logic [IdxW-1:0]              hit_idx_q [cift_pkg::NumKeys];
  logic [IdxW-1:0]              hit_idx_d [cift_pkg::NumKeys];
  logic                         free_q, free_d;
  logic [IdxW-1:0]              free_idx_q, free_idx_d;
  logic                         cur_valid;

  // Address stage
  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (start_i) begin
      busy_d = 1'b1;
      addr_d = '0;
    end else if (busy_q) begin
      if (addr_q == LastIdx) begin
        busy_d = 1'b0;
      end else begin
        addr_d = addr_q + 1'b1;
      end
    end
  end

  assign rd_en_o   = busy_q;
  assign rd_addr_o = addr_q;
  assign cur_valid = valid_i[cmp_idx_q];

  // Compare stage: keep the first hit of each key
  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (start_i) begin
      hit_d  = '0;
      free_d = 1'b0;
    end else if (cmp_vld_q) begin
      for (int k = 0; k < cift_pkg::NumKeys; k++) begin
        if (!hit_q[k] && cur_valid && (rd_data_i == key_i[k])) begin
          hit_d[k]     = 1'b1;
          hit_idx_d[k] = cmp_idx_q;
        end
      end
      if (!free_q && !cur_valid) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
      hit_q     <= '0;
      free_q    <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      addr_q    <= addr_d;
      cmp_vld_q <= busy_q;
      done_q    <= cmp_vld_q && (cmp_idx_q == LastIdx);
      hit_q     <= hit_d;
      free_q    <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= addr_q;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign status_o.done       = done_q;
  assign status_o.hit        = hit_q;
  assign status_o.free_found = free_q;
  assign hit_idx_o           = hit_idx_q;
  assign free_idx_o          = free_idx_q;

endmodule

// ===== rtl/core/can_id_filter_table_top.sv =====
// ----------------------------------------------------------------------------
// can_id_filter_table_top
// Receive-side CAN identifier filter table with insert, remove and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: tuser holds the command
//   (insert, remove, received frame lookup), tdata the 29-bit identifier.
//   m_axis returns one result per command: tuser holds the match kind,
//   tdata found, slot, table-full flag and both frame counters.
//   cfg_we_i/cfg_wdata_i write the enable bit; write it only while idle.
// Timing:
//   Every command sweeps the key memory one entry per cycle through its
//   single read port; a new command is taken only after the previous one
//   has finished its sweep and its result has been registered.
// Reset:
//   All entries are invalid, both counters are zero and the block is
//   enabled; it is ready for a command straight after reset.
// Stall:
//   A result waiting on m_axis does not block the next command; that
//   command is swept and then held until the waiting result is taken.
// ----------------------------------------------------------------------------
`include "can_id_filter_table_top_macros.svh"

module can_id_filter_table_top #(
  parameter int unsigned Entries = cift_pkg::EntriesDef,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // Command stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [cift_pkg::InDataW-1:0]  s_axis_tdata_i,  // identifier[28:0], zero pad
  input  logic [cift_pkg::CmdW-1:0]     s_axis_tuser_i,  // command[1:0]
  // Result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // found[0], slot[5:1], table_full[6], frames_received[38:7],
  // frames_decoded[70:39], zero pad[71]
  output logic [cift_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [cift_pkg::KindW-1:0]    m_axis_tuser_o   // match_kind[1:0]
);

  cift_pkg::state_e             state_q, state_d;
  cift_pkg::cmd_e               cmd_q;
  logic [cift_pkg::IdW-1:0]     id_q;
  logic                         enable_q;
  logic [Entries-1:0]           valid_q, valid_d;
  logic [cift_pkg::CntW-1:0]    rx_q, rx_d, dec_q, dec_d;

  logic                         accept;
  logic                         scan_start;
  logic                         fire;
  logic                         out_valid_q, out_valid_d;
  logic                         out_found_q, out_full_q;
  logic [cift_pkg::SlotW-1:0]   out_slot_q;
  cift_pkg::kind_e              out_kind_q;

  logic                         res_found, res_full;
  logic [IdxW-1:0]              res_idx;
  cift_pkg::kind_e              res_kind;
  logic [31:0]                  res_idx_ext;

  logic [cift_pkg::IdW-1:0]     keys [cift_pkg::NumKeys];
  logic                         ram_we, ram_re;
  logic [IdxW-1:0]              ram_raddr;
  logic [cift_pkg::IdW-1:0]     ram_rdata;
  cift_pkg::scan_status_t       scan_st;
  logic [IdxW-1:0]              hit_idx [cift_pkg::NumKeys];
  logic [IdxW-1:0]              free_idx;

  assign keys[cift_pkg::KeyExact] = id_q;
  assign keys[cift_pkg::KeyPrio]  = id_q & cift_pkg::PrioMask;
  assign keys[cift_pkg::KeyBcast] = (id_q & cift_pkg::PgnMask) | cift_pkg::BcastAddr;

  cift_ram #(
    .Width (cift_pkg::IdW),
    .Depth (Entries)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx),
    .wdata_i (id_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cift_scan #(
    .Entries (Entries)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .key_i      (keys),
    .valid_i    (valid_q),
    .rd_en_o    (ram_re),
    .rd_addr_o  (ram_raddr),
    .rd_data_i  (ram_rdata),
    .status_o   (scan_st),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cift_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = cift_pkg::ST_SCAN;
        end
      end
      cift_pkg::ST_SCAN: begin
        if (scan_st.done) begin
          state_d = cift_pkg::ST_FINISH;
        end
      end
      cift_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = cift_pkg::ST_IDLE;
        end
      end
      default: state_d = cift_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    fire            = 1'b0;
    case (state_q)
      cift_pkg::ST_IDLE:   s_axis_tready_o = 1'b1;
      cift_pkg::ST_SCAN:   fire = 1'b0;
      cift_pkg::ST_FINISH: fire = !out_valid_q || m_axis_tready_i;
      default:             fire = 1'b0;
    endcase
  end

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign scan_start = accept;

  // Resolve the sweep into a result and the table update
  always_comb begin
    res_found = 1'b0;
    res_full  = 1'b0;
    res_idx   = '0;
    res_kind  = cift_pkg::KIND_NONE;
    valid_d   = valid_q;
    ram_we    = 1'b0;
    rx_d      = rx_q;
    dec_d     = dec_q;
    case (cmd_q)
      cift_pkg::CMD_INSERT: begin
        if (scan_st.hit[cift_pkg::KeyExact]) begin
          res_found = 1'b1;
          res_idx   = hit_idx[cift_pkg::KeyExact];
          res_kind  = cift_pkg::KIND_EXACT;
        end else if (scan_st.free_found) begin
          res_idx           = free_idx;
          valid_d[free_idx] = 1'b1;
          ram_we            = fire;
        end else begin
          res_full = 1'b1;
        end
      end
      cift_pkg::CMD_REMOVE: begin
        if (scan_st.hit[cift_pkg::KeyExact]) begin
          res_found                         = 1'b1;
          res_idx                           = hit_idx[cift_pkg::KeyExact];
          res_kind                          = cift_pkg::KIND_EXACT;
          valid_d[hit_idx[cift_pkg::KeyExact]] = 1'b0;
        end
      end
      cift_pkg::CMD_LOOKUP: begin
        if (enable_q) begin
          rx_d = rx_q + 1'b1;
          if (scan_st.hit[cift_pkg::KeyExact]) begin
            res_found = 1'b1;
            res_idx   = hit_idx[cift_pkg::KeyExact];
            res_kind  = cift_pkg::KIND_EXACT;
          end else if (scan_st.hit[cift_pkg::KeyPrio]) begin
            res_found = 1'b1;
            res_idx   = hit_idx[cift_pkg::KeyPrio];
            res_kind  = cift_pkg::KIND_PRIO;
          end else if (scan_st.hit[cift_pkg::KeyBcast]) begin
            res_found = 1'b1;
            res_idx   = hit_idx[cift_pkg::KeyBcast];
            res_kind  = cift_pkg::KIND_BCAST;
          end
          if (res_found) begin
            dec_d = dec_q + 1'b1;
          end
        end
      end
      cift_pkg::CMD_NOP: res_found = 1'b0;
      default:           res_found = 1'b0;
    endcase
  end

  assign res_idx_ext = 32'(res_idx);

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cift_pkg::ST_IDLE;
      enable_q    <= 1'b1;
      valid_q     <= '0;
      rx_q        <= '0;
      dec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      // Commit table and counters together with the result
      if (fire) begin
        valid_q <= valid_d;
        rx_q    <= rx_d;
        dec_q   <= dec_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cift_pkg::cmd_e'(s_axis_tuser_i);
      id_q  <= s_axis_tdata_i[cift_pkg::IdW-1:0];
    end
    if (fire) begin
      out_found_q <= res_found;
      out_full_q  <= res_full;
      out_slot_q  <= res_idx_ext[cift_pkg::SlotW-1:0];
      out_kind_q  <= res_kind;
    end
  end

  // Counters change only on a result, so they double as the payload
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, dec_q, rx_q, out_full_q, out_slot_q, out_found_q};
  assign m_axis_tuser_o  = out_kind_q;

  `CIFT_ASSERT_NEXT(a_accept_starts_sweep, accept, (state_q == cift_pkg::ST_SCAN) && !s_axis_tready_o, "accepted command did not start a sweep")
  `CIFT_ASSERT_IMPL(a_write_new_key_only, ram_we, fire && (cmd_q == cift_pkg::CMD_INSERT) && !scan_st.hit[cift_pkg::KeyExact], "key memory written outside a fresh insert")
  `CIFT_ASSERT_IMPL(a_decoded_needs_received, dec_d != dec_q, rx_d != rx_q, "decoded count moved without a received frame")
  `CIFT_ASSERT_IMPL(a_full_not_found, m_axis_tvalid_o && out_full_q, !out_found_q && (out_kind_q == cift_pkg::KIND_NONE), "table-full result reports a match")

endmodule

// ===== tb/can_id_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_id_filter_checker
// Watches both streams of the CAN identifier filter table, keeps its own copy
// of the table and counters, predicts each result from the accepted command
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module can_id_filter_checker
  import cift_pkg::*;
#(
  parameter int unsigned Entries = EntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [CmdW-1:0]     s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic [KindW-1:0]    m_tuser_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  typedef struct {
    logic            found;
    logic [SlotW-1:0] slot;
    kind_e           kind;
    logic            full;
    logic [CntW-1:0] received;
    logic [CntW-1:0] decoded;
  } filter_result_t;

  logic [IdW-1:0]  table_key   [Entries];
  logic            table_valid [Entries];
  logic [CntW-1:0] received_cnt;
  logic [CntW-1:0] decoded_cnt;
  logic            enabled;

  filter_result_t  expected_results[$];

  // Lowest valid entry holding the key, or -1.
  function automatic int find_entry(logic [IdW-1:0] key);
    int hit;
    hit = -1;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (table_valid[i] && table_key[i] == key) hit = i;
    end
    return hit;
  endfunction

  function automatic filter_result_t apply_command(cmd_e cmd, logic [IdW-1:0] id);
    filter_result_t r;
    int hit;
    int free_slot;
    r.found = 1'b0;
    r.slot  = '0;
    r.kind  = KIND_NONE;
    r.full  = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        hit = find_entry(id);
        if (hit >= 0) begin
          r.found = 1'b1;
          r.slot  = hit[SlotW-1:0];
          r.kind  = KIND_EXACT;
        end else begin
          free_slot = -1;
          for (int i = Entries - 1; i >= 0; i--) begin
            if (!table_valid[i]) free_slot = i;
          end
          if (free_slot >= 0) begin
            table_valid[free_slot] = 1'b1;
            table_key[free_slot]   = id;
            r.slot = free_slot[SlotW-1:0];
          end else begin
            r.full = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        hit = find_entry(id);
        if (hit >= 0) begin
          table_valid[hit] = 1'b0;
          r.found = 1'b1;
          r.slot  = hit[SlotW-1:0];
          r.kind  = KIND_EXACT;
        end
      end
      CMD_LOOKUP: begin
        if (enabled) begin
          received_cnt = received_cnt + 1'b1;
          // try the full ID, then without priority, then the broadcast form
          hit    = find_entry(id);
          r.kind = KIND_EXACT;
          if (hit < 0) begin
            hit    = find_entry(id & PrioMask);
            r.kind = KIND_PRIO;
          end
          if (hit < 0) begin
            hit    = find_entry((id & PgnMask) | BcastAddr);
            r.kind = KIND_BCAST;
          end
          if (hit >= 0) begin
            decoded_cnt = decoded_cnt + 1'b1;
            r.found = 1'b1;
            r.slot  = hit[SlotW-1:0];
          end else begin
            r.kind = KIND_NONE;
          end
        end
      end
      default: ;
    endcase
    r.received = received_cnt;
    r.decoded  = decoded_cnt;
    return r;
  endfunction

  function automatic void note_field(string name, logic [CntW-1:0] exp_val,
                                     logic [CntW-1:0] act_val);
    if (exp_val !== act_val) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name,
                 exp_val, act_val);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filter_result_t oldest;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        table_key[i]   = '0;
        table_valid[i] = 1'b0;
      end
      received_cnt = '0;
      decoded_cnt  = '0;
      enabled      = 1'b1;
      expected_results.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) enabled = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i)
        expected_results.push_back(apply_command(cmd_e'(s_tuser_i), s_tdata_i[IdW-1:0]));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with nothing expected: tdata %0h tuser %0h", $realtime,
                     m_tdata_i, m_tuser_i);
        end else begin
          oldest = expected_results.pop_front();
          note_field("found", CntW'(oldest.found), CntW'(m_tdata_i[0]));
          note_field("slot", CntW'(oldest.slot), CntW'(m_tdata_i[5:1]));
          note_field("table_full", CntW'(oldest.full), CntW'(m_tdata_i[6]));
          note_field("frames_received", oldest.received, m_tdata_i[38:7]);
          note_field("frames_decoded", oldest.decoded, m_tdata_i[70:39]);
          note_field("match_kind", CntW'(oldest.kind), CntW'(m_tuser_i));
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, remove and lookup commands into the filter table: a directed
// opening on the match forms and corner IDs, then phases of random commands
// over a shifting key pool, with the enable bit changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import cift_pkg::*;

  localparam int unsigned Entries  = EntriesDef;
  localparam int unsigned Latency  = Entries + 3;
  localparam int unsigned PoolSize = 48;
  localparam int unsigned NumItems = 1300;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_wdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;   // identifier[28:0], zero pad
  logic [CmdW-1:0]     s_axis_tuser_i;   // command[1:0]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // found[0], slot[5:1], table_full[6], frames_received[38:7],
  // frames_decoded[70:39], zero pad[71]
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [KindW-1:0]    m_axis_tuser_o;   // match_kind[1:0]

  int pending;
  int fail_count;
  bit steady;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  can_id_filter_table_top #(.Entries(Entries)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  can_id_filter_checker #(.Entries(Entries)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tuser_i    (s_axis_tuser_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tuser_i    (m_axis_tuser_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(99) >= 29);
  end

  task automatic send_cmd(input cmd_e cmd, input logic [IdW-1:0] id);
    while (!steady && $urandom_range(99) < 29) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(InDataW - IdW){1'b0}}, id};
    s_axis_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Hold the sender until every outstanding result has been taken.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [IdW-1:0] key_pool [PoolSize];
    logic [IdW-1:0] id;
    logic [IdW-1:0] key;
    cmd_e           cmd;
    logic           enabled;
    int             counted;
    int             phase;
    int             mode;
    int             roll;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= CMD_NOP;
    m_axis_tready_i <= 1'b0;
    steady          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening
    send_cmd(CMD_LOOKUP, 29'h0000_0000);   // empty table
    send_cmd(CMD_INSERT, 29'h0000_0000);
    send_cmd(CMD_INSERT, 29'h1FFF_FFFF);
    send_cmd(CMD_INSERT, 29'h1FFF_FFFF);   // already present
    send_cmd(CMD_LOOKUP, 29'h1FFF_FFFF);
    send_cmd(CMD_INSERT, 29'h0012_3456);
    send_cmd(CMD_LOOKUP, 29'h1C12_3456);   // priority bits differ
    send_cmd(CMD_INSERT, 29'h00AB_CDFE);
    send_cmd(CMD_LOOKUP, 29'h1CAB_CD17);   // broadcast form
    send_cmd(CMD_LOOKUP, 29'h0400_0000);   // priority-masked onto zero
    send_cmd(CMD_REMOVE, 29'h1FFF_FFFF);
    send_cmd(CMD_REMOVE, 29'h1FFF_FFFF);   // absent now
    send_cmd(CMD_INSERT, 29'h0AAA_AAAA);   // reuses the freed slot
    send_cmd(CMD_LOOKUP, 29'h1555_5555);
    send_cmd(CMD_NOP,    29'h1FFF_FFFF);
    send_cmd(CMD_NOP,    29'h0000_0000);
    write_enable(1'b0);
    send_cmd(CMD_LOOKUP, 29'h0000_0000);
    send_cmd(CMD_LOOKUP, 29'h1CAB_CD17);
    send_cmd(CMD_INSERT, 29'h0155_55FE);
    write_enable(1'b1);
    send_cmd(CMD_LOOKUP, 29'h1FFF_FFFF);
    send_cmd(CMD_REMOVE, 29'h0000_0000);
    send_cmd(CMD_LOOKUP, 29'h0000_0000);

    for (int i = 0; i < PoolSize; i++) key_pool[i] = '0;
    counted = 0;
    phase   = 0;
    while (counted < NumItems) begin
      // Settle the enable bit and refresh the key pool between phases: all of it first, then about half
      if (phase == 0)      enabled = 1'b1;
      else if (phase == 2) enabled = 1'b0;
      else                 enabled = ($urandom_range(3) != 0);
      write_enable(enabled);
      steady = (phase == 1);
      mode   = (phase == 0) ? 0 : $urandom_range(2);
      for (int i = 0; i < PoolSize; i++) begin
        if (phase == 0 || $urandom_range(1) == 1) begin
          key = IdW'($urandom());
          case ($urandom_range(3))
            0: key_pool[i] = key;
            1: key_pool[i] = key & PrioMask;
            2: key_pool[i] = (key & PgnMask) | BcastAddr;
            default: key_pool[i] = $urandom_range(1) ? 29'h1FFF_FFFF : 29'h0000_0000;
          endcase
        end
      end

      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(99);
        key  = key_pool[$urandom_range(PoolSize - 1)];
        case (mode)
          0:       cmd = (roll < 60) ? CMD_INSERT : (roll < 70) ? CMD_REMOVE :
                         (roll < 95) ? CMD_LOOKUP : CMD_NOP;
          1:       cmd = (roll < 20) ? CMD_INSERT : (roll < 70) ? CMD_REMOVE :
                         (roll < 95) ? CMD_LOOKUP : CMD_NOP;
          default: cmd = (roll < 25) ? CMD_INSERT : (roll < 40) ? CMD_REMOVE :
                         (roll < 95) ? CMD_LOOKUP : CMD_NOP;
        endcase
        id = IdW'($urandom());
        if (cmd == CMD_LOOKUP) begin
          case ($urandom_range(3))
            0: id = key;
            1: id = {id[28:26], key[25:0]};
            2: id = {id[28:26], key[25:8], id[7:0]};
            default: ;
          endcase
        end else if ($urandom_range(9) != 0) begin
          id = key;
        end
        send_cmd(cmd, id);
        counted++;
      end
      phase++;
    end

    drain_results();
    steady = 1'b0;
    repeat (2 * Latency) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("can_id_filter_table_top test passed");
    end else begin
      $display("can_id_filter_table_top test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("can_id_filter_table_top test failed");
    $finish;
  end

endmodule
